[rtl/core/annexb_pkg.sv]
// Shared types, codes and helpers for the Annex B access unit splitter.
// No dependencies; used by annexb_access_unit_splitter_top.
package annexb_pkg;

  localparam int POS_BITS_DEF = 32;

  // Parse phases, numeric order matters (payload phases are >= PH_BODY, Exp-Golomb phases >= PH_FIRST)
  localparam logic [2:0] PH_SEEK   = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_FIRST  = 3'd3;
  localparam logic [2:0] PH_ZEROS  = 3'd4;
  localparam logic [2:0] PH_SUFFIX = 3'd5;

  localparam logic [1:0] ST_UNIT    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OVF     = 2'd2;

  // slice types run from NAL_SLICE up to NAL_IDR
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SEI   = 5'd6;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;
  localparam logic [4:0] NAL_AUD   = 5'd9;
  // SEI/SPS/PPS-like types that pull an access unit boundary back
  localparam logic [31:0] PREFIX_TYPES = 32'h0004_EDC0;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        slice;
    logic        key;
    logic [1:0]  status;
    logic        run_last;
    logic        stream_end;
  } res_t;

  // leading zeros of a byte, 8 when zero
  function automatic logic [3:0] lz8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) n = 4'(7 - i);
    end
    return n;
  endfunction

endpackage

[rtl/core/annexb_access_unit_splitter_top.sv]
// Annex B access unit splitter: start code search, slice header decode, unit cut.
// Depends on annexb_pkg. Contains the parser state and a 4-entry result queue.
// Results of a byte are registered into the result queue on its transfer.
// Throughput: one byte per cycle; a byte may yield up to two results, and the
// result queue stalls input when fewer than two entries are free.
// Reset: synchronous active-low rst_n clears parser state and empties the queue.
module annexb_access_unit_splitter_top #(
  parameter int POS_BITS = annexb_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] unit_offset, [63:32] unit_size,
                                  // [64] has_slice, [65] is_key_frame, zero pad
  output logic [2:0]  out_tuser,  // [1:0] status, [2] stream_end
  output logic        out_tlast   // run_last
);
  import annexb_pkg::*;

  localparam int PW = (POS_BITS > 32) ? POS_BITS : 32;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  logic [POS_BITS-1:0] pos_r, us_r, nb_r, pp_r;
  logic [1:0] zr_r, esc_r, ek_r;
  logic [2:0] ph_r;
  logic       pv_r, ss_r, si_r, er_r;
  logic [4:0] ct_r;
  logic [5:0] gz_r, grem_r;

  logic [POS_BITS-1:0] pos_nxt, us_nxt, nb_nxt, pp_nxt;
  logic [1:0] zr_nxt, esc_nxt, ek_nxt;
  logic [2:0] ph_nxt;
  logic       pv_nxt, ss_nxt, si_nxt, er_nxt;
  logic [4:0] ct_nxt;
  logic [5:0] gz_nxt, grem_nxt;

  res_t       mem [FIFO_DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  logic       acc, pop;
  logic [1:0] nres;
  res_t       r0, r1;

  function automatic logic [31:0] low32(input logic [POS_BITS-1:0] v);
    logic [PW-1:0] t;
    t = PW'(v);
    return t[31:0];
  endfunction

  assign acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;
  assign in_tready = (cnt_r <= 3'(FIFO_DEPTH - 2));

  always_comb begin
    logic [7:0]          b;
    logic                ea_v;
    logic [POS_BITS-1:0] ea_from, ea_to, cut, p;
    logic [2:0]          nzb, esum;
    logic [5:0]          nbits;
    logic [6:0]          s7;
    logic                feed_b;
    logic [5:0]          z0;
    logic [7:0]          win;
    logic [3:0]          kk, lz, left;
    res_t                fin;

    b = in_tdata;
    pos_nxt = pos_r; us_nxt = us_r; nb_nxt = nb_r; pp_nxt = pp_r;
    zr_nxt = zr_r; esc_nxt = esc_r; ek_nxt = ek_r; ph_nxt = ph_r;
    pv_nxt = pv_r; ss_nxt = ss_r; si_nxt = si_r; er_nxt = er_r;
    ct_nxt = ct_r; gz_nxt = gz_r; grem_nxt = grem_r;
    ea_v = 1'b0; ea_from = us_r; ea_to = nb_r; cut = nb_r;
    nzb = 3'd0; feed_b = 1'b0; esum = 3'd0; nbits = 6'd0; s7 = 7'd0;
    z0 = 6'd0; win = 8'd0; kk = 4'd8; lz = 4'd0; left = 4'd0;
    p = pos_r;
    r0 = '0; r1 = '0; nres = 2'd0; fin = '0;

    if (!er_nxt && p == POS_MAX) begin
      er_nxt = 1'b1;
      ek_nxt = ST_OVF;
    end
    if (!er_nxt) begin
      pos_nxt = p + POS_BITS'(1);
      if (ph_nxt == PH_SEEK) begin
        if (b == 8'd0) begin
          if (zr_nxt != 2'd3) zr_nxt = zr_nxt + 2'd1;
        end else if (b == 8'd1 && zr_nxt >= 2'd2) begin
          nb_nxt = p - ((zr_nxt == 2'd3) ? POS_BITS'(3) : POS_BITS'(2));
          zr_nxt = 2'd0;
          ph_nxt = PH_HEADER;
        end else begin
          er_nxt = 1'b1;
          ek_nxt = ST_INVALID;
        end
      end else if (ph_nxt == PH_HEADER) begin
        ct_nxt = b[4:0];
        zr_nxt = 2'd0;
        esc_nxt = 2'd0;
        ph_nxt = PH_BODY;
        if (b[4:0] == NAL_AUD) begin
          ea_v = ss_r;
          ea_from = us_r;
          ea_to = nb_r;
          us_nxt = nb_r;
          pv_nxt = 1'b0;
          ss_nxt = 1'b0;
          si_nxt = 1'b0;
        end else if (b[4:0] >= NAL_SLICE && b[4:0] <= NAL_IDR) begin
          ph_nxt = PH_FIRST;
        end else if (ss_r && !pv_r && PREFIX_TYPES[b[4:0]]) begin
          pp_nxt = nb_r;
          pv_nxt = 1'b1;
        end
      end else if (b == 8'd0) begin
        if (zr_nxt == 2'd3) nzb = 3'd1;
        else zr_nxt = zr_nxt + 2'd1;
      end else if (b == 8'd1 && zr_nxt >= 2'd2) begin
        if (ph_nxt >= PH_FIRST) begin
          er_nxt = 1'b1;
          ek_nxt = ST_INVALID;
        end
        nb_nxt = p - ((zr_nxt == 2'd3) ? POS_BITS'(3) : POS_BITS'(2));
        zr_nxt = 2'd0;
        ph_nxt = PH_HEADER;
      end else begin
        nzb = {1'b0, zr_nxt};
        zr_nxt = 2'd0;
        feed_b = 1'b1;
      end

      // trailing zeros are payload at the end of the stream
      if (in_tlast && !er_nxt && ph_nxt >= PH_BODY) begin
        nzb = nzb + {1'b0, zr_nxt};
        zr_nxt = 2'd0;
      end

      // run of zero bytes through the Exp-Golomb decoder
      if (!er_nxt && nzb != 3'd0 && ph_nxt >= PH_FIRST) begin
        esum = {1'b0, esc_nxt} + nzb;
        esc_nxt = (esum >= 3'd2) ? 2'd2 : esum[1:0];
        nbits = {nzb, 3'b000};
        if (ph_nxt == PH_FIRST) begin
          ss_nxt = 1'b1;
          if (ct_r == NAL_IDR) si_nxt = 1'b1;
          gz_nxt = nbits;
          ph_nxt = PH_ZEROS;
          if (nbits > 6'd31) begin
            er_nxt = 1'b1;
            ek_nxt = ST_INVALID;
          end
        end else if (ph_nxt == PH_ZEROS) begin
          s7 = {1'b0, gz_nxt} + {1'b0, nbits};
          if (s7 > 7'd31) begin
            er_nxt = 1'b1;
            ek_nxt = ST_INVALID;
          end else begin
            gz_nxt = s7[5:0];
          end
        end else if (grem_nxt <= nbits) begin
          ph_nxt = PH_BODY;
        end else begin
          grem_nxt = grem_nxt - nbits;
        end
      end

      // the nonzero byte itself
      if (feed_b && !er_nxt && ph_nxt >= PH_FIRST) begin
        if (esc_nxt >= 2'd2 && b == 8'd3) begin
          esc_nxt = 2'd0;   // emulation prevention byte
        end else begin
          esc_nxt = 2'd0;
          if (ph_nxt == PH_SUFFIX) begin
            if (grem_nxt <= 6'd8) ph_nxt = PH_BODY;
            else grem_nxt = grem_nxt - 6'd8;
          end else if (ph_nxt == PH_FIRST && b[7]) begin
            // first macroblock index is zero: new access unit
            if (ss_nxt) begin
              cut = pv_nxt ? pp_nxt : nb_nxt;
              ea_v = 1'b1;
              ea_from = us_nxt;
              ea_to = cut;
              us_nxt = cut;
              pv_nxt = 1'b0;
              si_nxt = 1'b0;
            end
            ss_nxt = 1'b1;
            if (ct_r == NAL_IDR) si_nxt = 1'b1;
            ph_nxt = PH_BODY;
          end else begin
            if (ph_nxt == PH_FIRST) begin
              ss_nxt = 1'b1;
              if (ct_r == NAL_IDR) si_nxt = 1'b1;
              z0 = 6'd1;
              win = {b[6:0], 1'b1};
              kk = 4'd7;
            end else begin
              z0 = gz_nxt;
              win = b;
              kk = 4'd8;
            end
            lz = lz8(win);
            s7 = {1'b0, z0} + 7'(lz);
            if (s7 > 7'd31) begin
              er_nxt = 1'b1;
              ek_nxt = ST_INVALID;
            end else begin
              gz_nxt = s7[5:0];
              left = kk - 4'd1 - lz;
              if (s7 <= 7'(left)) begin
                ph_nxt = PH_BODY;
              end else begin
                grem_nxt = s7[5:0] - 6'(left);
                ph_nxt = PH_SUFFIX;
              end
            end
          end
        end
      end
    end

    if (in_tlast && !er_nxt && ph_nxt != PH_BODY) begin
      er_nxt = 1'b1;
      ek_nxt = ST_INVALID;
    end

    r0.offset = low32(ea_from);
    r0.size = low32(ea_to - ea_from);
    r0.slice = 1'b1;
    r0.key = si_r;
    r0.status = ST_UNIT;
    r0.run_last = 1'b1;
    r0.stream_end = 1'b0;

    fin.offset = low32(us_nxt);
    fin.size = low32(pos_nxt - us_nxt);
    fin.slice = ss_nxt;
    fin.key = si_nxt;
    fin.status = ST_UNIT;
    fin.run_last = 1'b1;
    fin.stream_end = 1'b1;

    if (in_tlast) begin
      if (er_nxt) begin
        r0 = '0;
        r0.status = ek_nxt;
        r0.run_last = 1'b1;
        r0.stream_end = 1'b1;
        nres = 2'd1;
      end else if (ea_v) begin
        r0.run_last = 1'b0;
        r1 = fin;
        nres = 2'd2;
      end else begin
        r0 = fin;
        nres = 2'd1;
      end
      pos_nxt = '0; us_nxt = '0; nb_nxt = '0; pp_nxt = '0;
      zr_nxt = 2'd0; esc_nxt = 2'd0; ek_nxt = 2'd0; ph_nxt = PH_SEEK;
      pv_nxt = 1'b0; ss_nxt = 1'b0; si_nxt = 1'b0; er_nxt = 1'b0;
      ct_nxt = 5'd0; gz_nxt = 6'd0; grem_nxt = 6'd0;
    end else if (ea_v) begin
      nres = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; us_r <= '0; nb_r <= '0; pp_r <= '0;
      zr_r <= 2'd0; esc_r <= 2'd0; ek_r <= 2'd0; ph_r <= PH_SEEK;
      pv_r <= 1'b0; ss_r <= 1'b0; si_r <= 1'b0; er_r <= 1'b0;
      ct_r <= 5'd0; gz_r <= 6'd0; grem_r <= 6'd0;
    end else if (acc) begin
      pos_r <= pos_nxt; us_r <= us_nxt; nb_r <= nb_nxt; pp_r <= pp_nxt;
      zr_r <= zr_nxt; esc_r <= esc_nxt; ek_r <= ek_nxt; ph_r <= ph_nxt;
      pv_r <= pv_nxt; ss_r <= ss_nxt; si_r <= si_nxt; er_r <= er_nxt;
      ct_r <= ct_nxt; gz_r <= gz_nxt; grem_r <= grem_nxt;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (acc && nres != 2'd0) mem[wp_r] <= r0;
    if (acc && nres == 2'd2) mem[wp_r + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0;
      rp_r <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (acc) wp_r <= wp_r + nres;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + (acc ? {1'b0, nres} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  res_t head;
  assign head = mem[rp_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata = {6'd0, head.key, head.slice, head.size, head.offset};
  assign out_tuser = {head.stream_end, head.status};
  assign out_tlast = head.run_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(FIFO_DEPTH)) else $error("result queue overrun");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> ph_r == PH_SEEK && !er_r && pos_r == '0)
    else $error("parser not back in seek after stream end");

  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != ST_UNIT |-> out_tlast && out_tuser[2])
    else $error("error result not final");

  a_golomb_slice: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r == PH_ZEROS || ph_r == PH_SUFFIX |-> ss_r)
    else $error("golomb decode outside a slice");

endmodule
